/* rtl/core/earbd_pkg.sv */
// ----------------------------------------------------------------------------
// earbd_pkg
// shared types and constants of the eye aspect ratio blink detector
// ----------------------------------------------------------------------------
`default_nettype none

package earbd_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_EAR_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_MIN_FRAMES    = 8'd1;

    localparam logic [15:0] EAR_THRESHOLD_RESET = 16'd655;
    localparam logic [7:0]  MIN_FRAMES_RESET    = 8'd10;
    localparam int          FRAME_INDEX_BITS_DEFAULT = 16;

    localparam int NUM_ROLES  = 12;
    localparam int ROOT_STEPS = 17;   // 34-bit radicand, two bits a step
    localparam int DIV_STEPS  = 30;   // 30-bit dividend, one bit a step

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_SAVE,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_EYE,
        ST_EMIT
    } earbd_state_t;

    typedef struct packed {
        logic       wr;          // store the accepted landmark
        logic       seq_clr;     // restart the sequence
        logic       rd;          // read one landmark pair
        logic       sq;          // square the differences
        logic       root_init;   // load radicand
        logic       root_step;   // one root digit
        logic       dist_save;   // keep the finished distance
        logic       div_init;    // load dividend and divisor
        logic       div_step;    // one quotient bit
        logic       eye_save;    // keep the eye ratio
        logic       emit;        // load the result word
        logic       eye;         // 0 left, 1 right
        logic [1:0] slot;        // 0 v1, 1 v2, 2 width
    } earbd_cmd_t;

    typedef struct packed {
        logic out_free;
    } earbd_status_t;

endpackage

`default_nettype wire

/* rtl/core/eye_aspect_ratio_blink_detector_top.sv */
// ----------------------------------------------------------------------------
// eye_aspect_ratio_blink_detector_top
// per-frame eye aspect ratio with closed-eye and blink flags
// ----------------------------------------------------------------------------
// Landmarks come in one word per point, tagged by role (0-5 left eye, 6-11
// right eye; other roles are ignored but a frame end still acts). A word
// with tlast closes the frame: the six distances are formed one at a time
// (read pair, square, 17-step bit-serial root), each eye's ratio through a
// 30-step restoring divider, and one result word is produced. A landmark
// word is taken while the block is idle. After a frame-end word is taken
// s_tready stays low through the read, square, sum, root and save of each
// distance, three per eye, the divide and save of each eye's ratio, and the
// load of the result. The shared root and divide units set this wait, and it
// grows while a previous result still waits in the output register. Once
// the result is loaded, input flows again while the result waits. The
// frame counter saturates at 2^FRAME_INDEX_BITS-1; start_of_sequence clears
// it and the first-blink history before the same word's frame is scored.
// Configuration writes are always taken and should only be made when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module eye_aspect_ratio_blink_detector_top
    import earbd_pkg::*;
#(
    parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // landmark words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // coord_x, coord_y
    input  wire logic [4:0]  s_tuser,   // point_role, start_of_sequence
    input  wire logic        s_tlast,   // end_of_frame
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // ear_value, eyes_closed, blink_hit,
                                        // first_blink, frame_number,
                                        // blink_start, zero pad
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    earbd_cmd_t    cmd;
    earbd_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    earbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    // arithmetic and storage
    earbd_dp #(
        .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/core/earbd_ctrl.sv */
// ----------------------------------------------------------------------------
// earbd_ctrl
// sequencer stepping the datapath through distances, roots and divisions
// ----------------------------------------------------------------------------
`default_nettype none

module earbd_ctrl
    import earbd_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tlast,
    input  wire logic [4:0]    s_tuser,
    output earbd_cmd_t         cmd,
    input  wire earbd_status_t status
);

    earbd_state_t state_reg, state_next;
    logic         eye_reg, eye_next;
    logic [1:0]   slot_reg, slot_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic         accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            eye_reg   <= 1'b0;
            slot_reg  <= 2'd0;
            cnt_reg   <= 5'd0;
        end else begin
            state_reg <= state_next;
            eye_reg   <= eye_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        eye_next   = eye_reg;
        slot_next  = slot_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.eye    = eye_reg;
        cmd.slot   = slot_reg;
        s_tready   = (state_reg == ST_IDLE);
        accept     = s_tvalid && s_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.wr      = (s_tuser[3:0] < 4'(NUM_ROLES));
                    cmd.seq_clr = s_tuser[4];
                    if (s_tlast) begin
                        eye_next   = 1'b0;
                        slot_next  = 2'd0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.sq     = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.root_init = 1'b1;
                cnt_next      = 5'd0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_STEPS - 1)) begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE: begin
                cmd.dist_save = 1'b1;
                if (slot_reg == 2'd2) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    slot_next  = slot_reg + 2'd1;
                    state_next = ST_READ;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = 5'd0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_EYE;
                end
            end
            ST_EYE: begin
                cmd.eye_save = 1'b1;
                if (eye_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    eye_next   = 1'b1;
                    slot_next  = 2'd0;
                    state_next = ST_READ;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/earbd_dp.sv */
// ----------------------------------------------------------------------------
// earbd_dp
// landmark store, distance, root, divide and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module earbd_dp
    import earbd_pkg::*;
#(
    parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire earbd_cmd_t    cmd,
    output earbd_status_t      status,
    input  wire logic [31:0]   s_tdata,
    input  wire logic [4:0]    s_tuser,
    input  wire logic          cfg_valid,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [55:0]        m_tdata
);

    localparam int CW = FRAME_INDEX_BITS;

    logic [31:0] store_mem [NUM_ROLES];
    logic [31:0] rda_reg, rdb_reg;
    logic [3:0]  addr_a;

    logic [32:0] sqx_reg, sqy_reg;
    logic [33:0] rad_reg;
    logic [19:0] rem_reg;
    logic [16:0] root_reg;
    logic [16:0] v1_reg, v2_reg, h_reg;
    logic [29:0] num_reg, quo_reg;
    logic [17:0] den_reg;
    logic [18:0] drem_reg;
    logic [15:0] ear_l_reg, ear_r_reg;

    logic [15:0]   thr_reg;
    logic [7:0]    minf_reg;
    logic [CW-1:0] count_reg;
    logic          hit_seen_reg;
    logic          m_tvalid_reg;
    logic [55:0]   m_tdata_reg;

    logic signed [16:0] dx, dy;
    logic signed [33:0] px, py;
    logic [19:0] rem_sh, trial;
    logic [19:0] dtrial;
    logic [17:0] vsum;
    logic [15:0] eye_ear;
    logic [16:0] ear_sum;
    logic [15:0] ear, fnum, bstart;
    logic        closed, hit, first;

    // landmark store, x high half and y low half
    assign addr_a = (cmd.eye ? 4'd6 : 4'd0) + {1'b0, cmd.slot, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            store_mem[s_tuser[3:0]] <= {s_tdata[15:0], s_tdata[31:16]};
        end
        if (cmd.rd) begin
            rda_reg <= store_mem[addr_a];
            rdb_reg <= store_mem[addr_a + 4'd1];
        end
    end

    assign dx = signed'({1'b0, rda_reg[31:16]}) - signed'({1'b0, rdb_reg[31:16]});
    assign dy = signed'({1'b0, rda_reg[15:0]}) - signed'({1'b0, rdb_reg[15:0]});
    assign px = dx * dx;
    assign py = dy * dy;

    // restoring square root, two radicand bits a step
    assign rem_sh = {rem_reg[17:0], rad_reg[33:32]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // restoring divide, one quotient bit a step
    assign dtrial = {drem_reg, num_reg[29]};
    assign vsum   = {1'b0, v1_reg} + {1'b0, v2_reg};

    always_comb begin
        if (h_reg == 17'd0 || quo_reg[29:16] != 14'd0) begin
            eye_ear = 16'hFFFF;
        end else begin
            eye_ear = quo_reg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq) begin
            sqx_reg <= px[32:0];
            sqy_reg <= py[32:0];
        end
        if (cmd.root_init) begin
            rad_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg <= {rad_reg[31:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[15:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[15:0], 1'b0};
            end
        end
        if (cmd.dist_save) begin
            unique case (cmd.slot)
                2'd0:    v1_reg <= root_reg;
                2'd1:    v2_reg <= root_reg;
                default: h_reg  <= root_reg;
            endcase
        end
        if (cmd.div_init) begin
            num_reg  <= {vsum, 12'd0};
            den_reg  <= {h_reg, 1'b0};
            drem_reg <= '0;
            quo_reg  <= '0;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[28:0], 1'b0};
            if (dtrial >= {2'b00, den_reg}) begin
                drem_reg <= 19'(dtrial - {2'b00, den_reg});
                quo_reg  <= {quo_reg[28:0], 1'b1};
            end else begin
                drem_reg <= dtrial[18:0];
                quo_reg  <= {quo_reg[28:0], 1'b0};
            end
        end
        if (cmd.eye_save) begin
            if (cmd.eye) begin
                ear_r_reg <= eye_ear;
            end else begin
                ear_l_reg <= eye_ear;
            end
        end
    end

    // frame result
    assign ear_sum = {1'b0, ear_l_reg} + {1'b0, ear_r_reg};
    assign ear     = ear_sum[16:1];
    assign fnum    = (32'(count_reg) > 32'd65535) ? 16'hFFFF : 16'(count_reg);
    assign closed  = (ear <= thr_reg);
    assign hit     = (ear < thr_reg) && (32'(count_reg) > 32'(minf_reg));
    assign first   = hit && !hit_seen_reg;
    assign bstart  = hit ? (fnum - {8'd0, minf_reg}) : 16'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= EAR_THRESHOLD_RESET;
            minf_reg     <= MIN_FRAMES_RESET;
            count_reg    <= '0;
            hit_seen_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == REG_EAR_THRESHOLD) begin
                thr_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_MIN_FRAMES) begin
                minf_reg <= cfg_data[7:0];
            end
            if (cmd.seq_clr) begin
                count_reg    <= '0;
                hit_seen_reg <= 1'b0;
            end else if (cmd.emit) begin
                if (count_reg != {CW{1'b1}}) begin
                    count_reg <= count_reg + CW'(1);
                end
                if (hit) begin
                    hit_seen_reg <= 1'b1;
                end
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {5'd0, bstart, fnum, first, hit, closed, ear};
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* dv/earbd_checker.sv */
// ----------------------------------------------------------------------------
// earbd_checker
// scoreboard for the eye aspect ratio blink detector
// ----------------------------------------------------------------------------
// Watches the landmark, result and register channels. It keeps its own copy
// of the landmark store, the frame counter and the registers, predicts one
// result word per frame-end word, and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module earbd_checker
    import earbd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [4:0]  s_tuser,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               frames_seen,
    output int               hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] blink_start;
        logic [15:0] frame_number;
        logic        first_blink;
        logic        blink_hit;
        logic        eyes_closed;
        logic [15:0] ear_value;
    } frame_result_t;

    logic [15:0]   px [NUM_ROLES];
    logic [15:0]   py [NUM_ROLES];
    logic [15:0]   frame_cnt;
    logic          hit_flag;
    logic [15:0]   thresh;
    logic [7:0]    min_fr;
    frame_result_t expected_frames [$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned span(int a, int b);
        longint signed dx;
        longint signed dy;
        dx = longint'(px[a]) - longint'(px[b]);
        dy = longint'(py[a]) - longint'(py[b]);
        return int_sqrt(longint'(dx * dx + dy * dy));
    endfunction

    // aspect ratio of one eye, q4.12, zero width saturates
    function automatic longint unsigned eye_ratio(int base);
        longint unsigned v1;
        longint unsigned v2;
        longint unsigned h;
        longint unsigned q;
        v1 = span(base, base + 1);
        v2 = span(base + 2, base + 3);
        h  = span(base + 4, base + 5);
        if (h == 0) return 65535;
        q = ((v1 + v2) << 12) / (2 * h);
        return (q > 65535) ? 65535 : q;
    endfunction

    function automatic frame_result_t score_frame();
        frame_result_t r;
        longint unsigned ear;
        ear = (eye_ratio(0) + eye_ratio(6)) >> 1;
        r.ear_value    = ear[15:0];
        r.eyes_closed  = ear <= thresh;
        r.blink_hit    = (ear < thresh) && (frame_cnt > min_fr);
        r.first_blink  = r.blink_hit && !hit_flag;
        r.frame_number = frame_cnt;
        r.blink_start  = r.blink_hit ? frame_cnt - 16'(min_fr) : 16'd0;
        return r;
    endfunction

    always @(posedge aclk) begin
        frame_result_t exp_r;
        frame_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_ROLES; i++) begin
                px[i] = '0;
                py[i] = '0;
            end
            frame_cnt = '0;
            hit_flag  = 1'b0;
            thresh    = EAR_THRESHOLD_RESET;
            min_fr    = MIN_FRAMES_RESET;
            expected_frames.delete();
            fail_count  = 0;
            frames_seen = 0;
            hits_seen   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_EAR_THRESHOLD) thresh = cfg_data;
                else if (cfg_index == REG_MIN_FRAMES) min_fr = cfg_data[7:0];
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[3:0] < NUM_ROLES) begin
                    px[s_tuser[3:0]] = s_tdata[15:0];
                    py[s_tuser[3:0]] = s_tdata[31:16];
                end
                // sequence restart comes before scoring the same word
                if (s_tuser[4]) begin
                    frame_cnt = '0;
                    hit_flag  = 1'b0;
                end
                if (s_tlast) begin
                    exp_r = score_frame();
                    if (exp_r.blink_hit) hit_flag = 1'b1;
                    expected_frames.insert(expected_frames.size(), exp_r);
                    if (frame_cnt != 16'hffff) frame_cnt++;
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[50:0];
                if (expected_frames.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_frames.pop_front();
                    frames_seen++;
                    if (exp_r.blink_hit) hits_seen++;
                    if (got.ear_value !== exp_r.ear_value) begin
                        $error("ear_value expected %0d got %0d",
                               exp_r.ear_value, got.ear_value);
                        fail_count++;
                    end
                    if (got.eyes_closed !== exp_r.eyes_closed) begin
                        $error("eyes_closed expected %0d got %0d",
                               exp_r.eyes_closed, got.eyes_closed);
                        fail_count++;
                    end
                    if (got.blink_hit !== exp_r.blink_hit) begin
                        $error("blink_hit expected %0d got %0d",
                               exp_r.blink_hit, got.blink_hit);
                        fail_count++;
                    end
                    if (got.first_blink !== exp_r.first_blink) begin
                        $error("first_blink expected %0d got %0d",
                               exp_r.first_blink, got.first_blink);
                        fail_count++;
                    end
                    if (got.frame_number !== exp_r.frame_number) begin
                        $error("frame_number expected %0d got %0d",
                               exp_r.frame_number, got.frame_number);
                        fail_count++;
                    end
                    if (got.blink_start !== exp_r.blink_start) begin
                        $error("blink_start expected %0d got %0d",
                               exp_r.blink_start, got.blink_start);
                        fail_count++;
                    end
                end
            end
            pending = expected_frames.size();
        end
    end

    initial pending = 0;

endmodule

`default_nettype wire

/* dv/eye_aspect_ratio_blink_detector_top_test.sv */
// ----------------------------------------------------------------------------
// eye_aspect_ratio_blink_detector_top_test
// stimulus and verdict for the eye aspect ratio blink detector
// ----------------------------------------------------------------------------
// Sends directed landmark frames (coordinate extremes, zero width, unknown
// roles, restart on a frame end), then random eye shapes across several
// threshold and minimum-frame settings, with bursty input and a stalling
// result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module eye_aspect_ratio_blink_detector_top_test;
    import earbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 20000;  // cycles with no word moving
    localparam int DRAIN_WAIT  = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // coord_x, coord_y
    logic [4:0]  s_tuser;    // point_role, start_of_sequence
    logic        s_tlast;    // end_of_frame
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // ear_value, eyes_closed, blink_hit, first_blink,
                             // frame_number, blink_start, zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int pending;
    int frames_seen;
    int hits_seen;
    int idle_cycles;
    int burst_left;
    int stall_mode;
    int stall_timer;

    eye_aspect_ratio_blink_detector_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    earbd_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .frames_seen(frames_seen),
        .hits_seen  (hits_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side: stall pattern is redrawn whenever its timer runs out,
    // mode 0 never stalls, mode 1 stalls at random, mode 2 long stalls
    initial begin
        m_tready    = 1'b0;
        stall_mode  = 0;
        stall_timer = 0;
        forever begin
            @(posedge aclk);
            if (stall_timer == 0) begin
                stall_mode  = $urandom_range(0, 2);
                stall_timer = $urandom_range(100, 600);
            end
            stall_timer--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // watchdog: any word moving on any channel resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one landmark word; sender idles between bursts of random length
    task automatic send_point(input logic [3:0] role, input logic [15:0] x,
                              input logic [15:0] y, input logic eof,
                              input logic sos);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 15);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= {sos, role};
        s_tlast  <= eof;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        burst_left--;
    endtask

    // register write, only once every result is out and the block is idle
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // full frame, all twelve roles at one coordinate
    task automatic flat_frame(input logic [15:0] x, input logic [15:0] y,
                              input logic sos);
        for (int r = 0; r < NUM_ROLES; r++)
            send_point(4'(r), x, y, r == NUM_ROLES - 1, sos && r == 0);
    endtask

    // random eye shapes: width, opening and center chosen per eye so the
    // ratio lands on both sides of the threshold; some frames fully random
    task automatic random_frame(input logic sos);
        int cx, cy, w, o1, o2;
        logic [15:0] xs [NUM_ROLES];
        logic [15:0] ys [NUM_ROLES];
        int wild;
        wild = ($urandom_range(0, 4) == 0);
        for (int e = 0; e < 2; e++) begin
            cx = $urandom_range(16384, 49151);
            cy = $urandom_range(16384, 49151);
            w  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16000);
            o1 = $urandom_range(0, ($urandom_range(0, 1) ? w / 4 : w) / 2 + 1);
            o2 = $urandom_range(0, o1 + 8);
            xs[e*6+0] = 16'(cx - w/4); ys[e*6+0] = 16'(cy - o1);
            xs[e*6+1] = 16'(cx - w/4); ys[e*6+1] = 16'(cy + o1);
            xs[e*6+2] = 16'(cx + w/4); ys[e*6+2] = 16'(cy - o2);
            xs[e*6+3] = 16'(cx + w/4); ys[e*6+3] = 16'(cy + o2);
            xs[e*6+4] = 16'(cx + w/2); ys[e*6+4] = 16'(cy);
            xs[e*6+5] = 16'(cx - w/2); ys[e*6+5] = 16'(cy);
        end
        for (int r = 0; r < NUM_ROLES; r++) begin
            if (wild) begin
                xs[r] = 16'($urandom);
                ys[r] = 16'($urandom);
            end
            // occasional noise word with an unknown role
            if ($urandom_range(0, 9) == 0)
                send_point(4'($urandom_range(12, 15)), 16'($urandom),
                           16'($urandom), 1'b0, 1'b0);
            // sometimes a frame only refreshes some roles
            if (r == NUM_ROLES - 1 || $urandom_range(0, 15) != 0)
                send_point(4'(r), xs[r], ys[r], r == NUM_ROLES - 1,
                           sos && r == 0);
        end
    endtask

    initial begin
        logic [15:0] thresholds [5];
        logic [7:0]  min_counts [5];
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        idle_cycles = 0;
        thresholds = '{EAR_THRESHOLD_RESET, 16'd0, 16'hffff, 16'($urandom), 16'd4096};
        min_counts = '{MIN_FRAMES_RESET, 8'd0, 8'd255, 8'($urandom), 8'd3};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero width, unknown role, restart on frame end
        for (int r = 0; r < NUM_ROLES; r++)
            send_point(4'(r), (r % 2) ? 16'hffff : 16'h0000,
                       (r % 3) ? 16'hffff : 16'h0000, r == NUM_ROLES - 1, r == 0);
        flat_frame(16'h8000, 16'h8000, 1'b0);                    // both eyes zero width
        send_point(4'd15, 16'hffff, 16'hffff, 1'b1, 1'b0);       // unknown role ends frame
        send_point(4'd3, 16'h1234, 16'hfedc, 1'b1, 1'b1);        // restart and end at once
        send_point(4'd12, 16'h0000, 16'h0000, 1'b1, 1'b0);

        // random phases, one register setting each
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_EAR_THRESHOLD, thresholds[p]);
            write_reg(REG_MIN_FRAMES, 16'(min_counts[p]));
            for (int f = 0; f < 26; f++)
                random_frame($urandom_range(0, 39) == 0);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d frames, %0d blink hits, five register settings",
                 frames_seen, hits_seen);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/earbd_pkg.sv
rtl/core/earbd_ctrl.sv
rtl/core/earbd_dp.sv
rtl/core/eye_aspect_ratio_blink_detector_top.sv
dv/earbd_checker.sv
dv/eye_aspect_ratio_blink_detector_top_test.sv
